@@ rtl/core/ptm_pkg.sv @@
package ptm_pkg;

  localparam int PTM_COUNTER_WIDTH = 32;
  localparam int PTM_RATE_W        = 19;
  localparam int PTM_TOL_W         = 32;
  localparam int PTM_FRAMES_W      = 16;
  localparam int PTM_STAMP_W       = 64;
  localparam int PTM_SPAN_W        = 40;
  localparam int PTM_SEEN_W        = 48;
  localparam int PTM_TOTAL_W       = 32;

  // 10^7 ticks of 100 ns per second
  localparam int PTM_TICKS_W = 24;
  localparam logic [PTM_TICKS_W-1:0] PTM_TICKS = 24'd10_000_000;

  // dividend frames * ticks + rate / 2 fits in 40 bits
  localparam int PTM_NUM_W = PTM_FRAMES_W + PTM_TICKS_W;

  localparam logic [PTM_RATE_W-1:0] PTM_RATE_RESET = 19'd48000;
  localparam logic [PTM_TOL_W-1:0]  PTM_TOL_RESET  = 32'd10000;

  // apb register map
  localparam int PTM_ADDR_W = 3;
  localparam logic PTM_REG_RATE          = 1'b0;
  localparam logic PTM_REG_GAP_TOLERANCE = 1'b1;

  typedef struct packed {
    logic [15:0] frame_count;
    logic [63:0] device_pos;
    logic [63:0] stamp;
    logic        discontinuity;
    logic        stamp_error;
  } ptm_in_t;

  typedef struct packed {
    logic [31:0] discontinuity_total;
    logic [31:0] stamp_error_total;
    logic [31:0] gap_total;
    logic [31:0] regression_total;
    logic        gap_seen;
    logic        regression_seen;
    logic        timeline_ok;
    logic [39:0] span_frames;
    logic [63:0] span_ticks;
    logic [47:0] frames_total;
  } ptm_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_STEP,
    S_DIFF,
    S_FIN
  } ptm_state_t;

endpackage

@@ rtl/core/ptm_in_if.sv @@
interface ptm_in_if;
  import ptm_pkg::*;

  logic    valid;
  logic    ready;
  ptm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport mon (input valid, input data, input ready);
endinterface

@@ rtl/core/ptm_out_if.sv @@
interface ptm_out_if;
  import ptm_pkg::*;

  logic     valid;
  logic     ready;
  ptm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport mon (input valid, input data, input ready);
endinterface

@@ rtl/core/packet_timeline_monitor_top.sv @@
// channel   direction  protocol      payload
// in_if     in         valid/ready   frame_count, device_pos, stamp, flags
// out_if    out        valid/ready   totals, per-packet flags, spans
// cfg_*     in/out     apb, 32 bit   0x0 frame rate, 0x4 gap_tolerance
//
// each beat goes through the 40-step restoring divider that predicts the timestamp step;
// the next beat is accepted only once the previous one has reached the finish step.
// in_if.ready is high only in idle; a waiting result does not block the next accept.
// if the previous result is still untaken, the finish step waits for it.
// rst_n is synchronous, active low, and clears all counters and timeline state.
module packet_timeline_monitor_top #(
  parameter int COUNTER_WIDTH = ptm_pkg::PTM_COUNTER_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ptm_in_if.sink                          in_if,
  ptm_out_if.source                       out_if,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ptm_pkg::PTM_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import ptm_pkg::*;

  localparam int CNT_W  = $clog2(PTM_NUM_W);
  localparam int REM_W  = PTM_RATE_W + 1;

  ptm_state_t state_r, state_nxt;

  // configuration
  logic [PTM_RATE_W-1:0] rate_r;
  logic [PTM_TOL_W-1:0]  tol_r;
  logic                  cfg_wr;

  // latched beat
  ptm_in_t item_r;

  // timeline state
  logic [COUNTER_WIDTH-1:0] disc_cnt_r, serr_cnt_r, gap_cnt_r, regr_cnt_r;
  logic                     tl_valid_r;
  logic [PTM_STAMP_W-1:0]   base_stamp_r, prev_stamp_r, prev_pos_r;
  logic [PTM_FRAMES_W-1:0]  prev_frames_r;
  logic [PTM_SPAN_W-1:0]    fsb_r;
  logic [PTM_SEEN_W-1:0]    seen_r;

  // timestamp step divider
  logic [PTM_NUM_W-1:0]  num_r;
  logic [REM_W-1:0]      rem_r;
  logic [PTM_RATE_W-1:0] div_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [REM_W-1:0]      rem_sh;
  logic                  q_bit;
  logic [PTM_RATE_W-1:0] rate_eff;

  logic [PTM_STAMP_W-1:0] actual_r, diff_r, span_r;

  logic out_valid_r;
  ptm_out_t out_r;

  logic fin_go, load_item, qual, check, gap, regress;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    case (cfg_paddr[2])
      PTM_REG_RATE:          cfg_prdata = 32'(rate_r);
      PTM_REG_GAP_TOLERANCE: cfg_prdata = tol_r;
      default:               cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= PTM_RATE_RESET;
      tol_r  <= PTM_TOL_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        PTM_REG_RATE:          rate_r <= cfg_pwdata[PTM_RATE_W-1:0];
        PTM_REG_GAP_TOLERANCE: tol_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- fsm
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_if.valid) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (cnt_r == CNT_W'(PTM_NUM_W - 1)) state_nxt = S_STEP;
      S_STEP: state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_FIN;
      S_FIN:  if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = 1'b0;
    load_item   = 1'b0;
    fin_go      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_if.ready = 1'b1;
        load_item   = in_if.valid;
      end
      S_FIN: fin_go = !out_valid_r || out_if.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------------------------------------------------------- datapath
  assign rate_eff = (rate_r == '0) ? PTM_RATE_W'(1) : rate_r;
  assign rem_sh   = {rem_r[REM_W-2:0], num_r[PTM_NUM_W-1]};
  assign q_bit    = rem_sh >= REM_W'(div_r);

  assign qual    = !item_r.discontinuity && !item_r.stamp_error;
  assign check   = qual && tl_valid_r;
  assign gap     = check && (diff_r > PTM_STAMP_W'(tol_r));
  assign regress = check && (item_r.device_pos < prev_pos_r);

  always_ff @(posedge clk) begin
    if (load_item) item_r <= in_if.data;
    case (state_r)
      S_MUL: begin
        num_r <= PTM_NUM_W'(prev_frames_r) * PTM_NUM_W'(PTM_TICKS)
               + PTM_NUM_W'(rate_eff >> 1);
        rem_r <= '0;
        div_r <= rate_eff;
        cnt_r <= '0;
      end
      S_DIV: begin
        // restoring step, quotient shifts in from the right
        rem_r <= q_bit ? rem_sh - REM_W'(div_r) : rem_sh;
        num_r <= {num_r[PTM_NUM_W-2:0], q_bit};
        cnt_r <= cnt_r + 1'b1;
      end
      S_STEP: begin
        actual_r <= (item_r.stamp >= prev_stamp_r) ? item_r.stamp - prev_stamp_r : '0;
        // span against the state this beat leaves behind
        if (qual && !tl_valid_r) span_r <= '0;
        else if (qual)
          span_r <= (item_r.stamp >= base_stamp_r) ? item_r.stamp - base_stamp_r : '0;
        else
          span_r <= (prev_stamp_r >= base_stamp_r) ? prev_stamp_r - base_stamp_r : '0;
      end
      S_DIFF: begin
        diff_r <= (actual_r > PTM_STAMP_W'(num_r)) ? actual_r - PTM_STAMP_W'(num_r)
                                                    : PTM_STAMP_W'(num_r) - actual_r;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- timeline update
  logic [COUNTER_WIDTH-1:0] disc_nxt, serr_nxt, gap_nxt, regr_nxt;
  logic [PTM_SPAN_W:0]      fsb_sum;
  logic [PTM_SPAN_W-1:0]    fsb_nxt;
  logic [PTM_SEEN_W:0]      seen_sum;
  logic [PTM_SEEN_W-1:0]    seen_nxt;

  always_comb begin
    disc_nxt = disc_cnt_r;
    serr_nxt = serr_cnt_r;
    gap_nxt  = gap_cnt_r;
    regr_nxt = regr_cnt_r;
    if (item_r.discontinuity && !(&disc_cnt_r)) disc_nxt = disc_cnt_r + 1'b1;
    if (item_r.stamp_error && !(&serr_cnt_r))   serr_nxt = serr_cnt_r + 1'b1;
    if (gap && !(&gap_cnt_r))                   gap_nxt  = gap_cnt_r + 1'b1;
    if (regress && !(&regr_cnt_r))              regr_nxt = regr_cnt_r + 1'b1;

    fsb_sum = {1'b0, fsb_r} + (PTM_SPAN_W + 1)'(prev_frames_r);
    if (qual && !tl_valid_r)   fsb_nxt = '0;
    else if (check)            fsb_nxt = fsb_sum[PTM_SPAN_W] ? '1 : fsb_sum[PTM_SPAN_W-1:0];
    else                       fsb_nxt = fsb_r;

    seen_sum = {1'b0, seen_r} + (PTM_SEEN_W + 1)'(item_r.frame_count);
    seen_nxt = seen_sum[PTM_SEEN_W] ? '1 : seen_sum[PTM_SEEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disc_cnt_r    <= '0;
      serr_cnt_r    <= '0;
      gap_cnt_r     <= '0;
      regr_cnt_r    <= '0;
      tl_valid_r    <= 1'b0;
      base_stamp_r  <= '0;
      prev_stamp_r  <= '0;
      prev_pos_r    <= '0;
      prev_frames_r <= '0;
      fsb_r         <= '0;
      seen_r        <= '0;
    end else if (fin_go) begin
      disc_cnt_r <= disc_nxt;
      serr_cnt_r <= serr_nxt;
      gap_cnt_r  <= gap_nxt;
      regr_cnt_r <= regr_nxt;
      tl_valid_r <= qual;
      fsb_r      <= fsb_nxt;
      seen_r     <= seen_nxt;
      if (qual) begin
        if (!tl_valid_r) base_stamp_r <= item_r.stamp;
        prev_stamp_r  <= item_r.stamp;
        prev_pos_r    <= item_r.device_pos;
        prev_frames_r <= item_r.frame_count;
      end
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n)            out_valid_r <= 1'b0;
    else if (fin_go)       out_valid_r <= 1'b1;
    else if (out_if.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_r.discontinuity_total <= PTM_TOTAL_W'(disc_nxt);
      out_r.stamp_error_total   <= PTM_TOTAL_W'(serr_nxt);
      out_r.gap_total           <= PTM_TOTAL_W'(gap_nxt);
      out_r.regression_total    <= PTM_TOTAL_W'(regr_nxt);
      out_r.gap_seen            <= gap;
      out_r.regression_seen     <= regress;
      out_r.timeline_ok         <= qual;
      out_r.span_frames         <= fsb_nxt;
      out_r.span_ticks          <= span_r;
      out_r.frames_total        <= seen_nxt;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

endmodule

@@ rtl/core/ptm_checker.sv @@
module ptm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ptm_pkg::ptm_out_t out_data
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // the block is busy right after it takes a beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

  // gaps and regressions only come from qualified packets
  a_flag_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.gap_seen || out_data.regression_seen)
      |-> out_data.timeline_ok)
    else $error("gap or regression on a broken timeline");

  // no result appears out of reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind packet_timeline_monitor_top ptm_checker u_ptm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);

@@ bench/packet_timeline_monitor_top_tb.sv @@
`timescale 1ns / 100ps

module packet_timeline_monitor_top_tb;
  import ptm_pkg::*;

  localparam logic [63:0] TICKS_PER_SEC = 64'd10_000_000;
  localparam logic [PTM_ADDR_W-1:0] RATE_ADDR = {PTM_REG_RATE, 2'b00};
  localparam logic [PTM_ADDR_W-1:0] TOL_ADDR  = {PTM_REG_GAP_TOLERANCE, 2'b00};
  localparam int HOLD_CYCLES = 600;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [PTM_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  ptm_in_if  in_ch ();
  ptm_out_if out_ch ();

  packet_timeline_monitor_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // timeline state as the block should hold it
  logic [PTM_RATE_W-1:0]        rate_reg;
  logic [PTM_TOL_W-1:0]         tol_reg;
  logic [PTM_COUNTER_WIDTH-1:0] disc_cnt, serr_cnt, gap_cnt, regr_cnt;
  logic                         tl_valid;
  logic [63:0]                  base_stamp, last_stamp, last_pos;
  logic [15:0]                  last_frames;
  logic [PTM_SPAN_W-1:0]        span_acc;
  logic [PTM_SEEN_W-1:0]        frames_acc;

  ptm_out_t pending_reports[$];
  int       fault_count;

  // stream generator follows the last packet sent
  logic [63:0] gen_stamp, gen_pos;
  logic [15:0] gen_frames;
  int          gap_max;
  int          burst_left;
  int          hold_requests;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [PTM_COUNTER_WIDTH-1:0] bump_count(
    input logic [PTM_COUNTER_WIDTH-1:0] c
  );
    return (&c) ? c : c + 1'b1;
  endfunction

  // nominal timestamp advance for a packet, rounded half up
  function automatic logic [63:0] step_ticks(input logic [15:0] frames);
    logic [63:0] rate;
    rate = (rate_reg == '0) ? 64'd1 : {{(64 - PTM_RATE_W){1'b0}}, rate_reg};
    return ({48'd0, frames} * TICKS_PER_SEC + (rate >> 1)) / rate;
  endfunction

  function automatic ptm_out_t predict_report(input ptm_in_t p);
    ptm_out_t    r;
    logic        qualified;
    logic [63:0] want_step, got_step, step_err;
    logic [PTM_SPAN_W:0] span_sum;
    logic [PTM_SEEN_W:0] seen_sum;
    r = '0;
    qualified = !p.discontinuity && !p.stamp_error;
    if (p.discontinuity) disc_cnt = bump_count(disc_cnt);
    if (p.stamp_error) serr_cnt = bump_count(serr_cnt);
    if (qualified && tl_valid) begin
      want_step = step_ticks(last_frames);
      got_step = (p.stamp >= last_stamp) ? p.stamp - last_stamp : 64'd0;
      step_err = (got_step > want_step) ? got_step - want_step : want_step - got_step;
      if (step_err > {32'd0, tol_reg}) begin
        r.gap_seen = 1'b1;
        gap_cnt = bump_count(gap_cnt);
      end
      span_sum = {1'b0, span_acc} + (PTM_SPAN_W + 1)'(last_frames);
      span_acc = span_sum[PTM_SPAN_W] ? '1 : span_sum[PTM_SPAN_W-1:0];
      if (p.device_pos < last_pos) begin
        r.regression_seen = 1'b1;
        regr_cnt = bump_count(regr_cnt);
      end
    end
    if (qualified) begin
      if (!tl_valid) begin
        base_stamp = p.stamp;
        span_acc = '0;
      end
      tl_valid = 1'b1;
      last_stamp = p.stamp;
      last_frames = p.frame_count;
      last_pos = p.device_pos;
    end else begin
      tl_valid = 1'b0;
    end
    seen_sum = {1'b0, frames_acc} + (PTM_SEEN_W + 1)'(p.frame_count);
    frames_acc = seen_sum[PTM_SEEN_W] ? '1 : seen_sum[PTM_SEEN_W-1:0];
    r.discontinuity_total = disc_cnt[31:0];
    r.stamp_error_total   = serr_cnt[31:0];
    r.gap_total           = gap_cnt[31:0];
    r.regression_total    = regr_cnt[31:0];
    r.timeline_ok         = tl_valid;
    r.span_frames         = span_acc;
    r.span_ticks          = (last_stamp >= base_stamp) ? last_stamp - base_stamp : 64'd0;
    r.frames_total        = frames_acc;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endfunction

  always @(posedge clk) begin
    ptm_out_t want;
    ptm_out_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_reports.size() == 0) begin
        $error("result beat with no packet waiting");
        fault_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("discontinuity_total", 64'(want.discontinuity_total),
                    64'(got.discontinuity_total));
        check_field("stamp_error_total", 64'(want.stamp_error_total),
                    64'(got.stamp_error_total));
        check_field("gap_total", 64'(want.gap_total), 64'(got.gap_total));
        check_field("regression_total", 64'(want.regression_total),
                    64'(got.regression_total));
        check_field("gap_seen", 64'(want.gap_seen), 64'(got.gap_seen));
        check_field("regression_seen", 64'(want.regression_seen), 64'(got.regression_seen));
        check_field("timeline_ok", 64'(want.timeline_ok), 64'(got.timeline_ok));
        check_field("span_frames", 64'(want.span_frames), 64'(got.span_frames));
        check_field("span_ticks", want.span_ticks, got.span_ticks);
        check_field("frames_total", 64'(want.frames_total), 64'(got.frames_total));
      end
    end
  end

  // receiver: its own stall pattern, plus a long hold when one is requested
  initial begin
    int rx_mode;
    int mode_left;
    int rx_run;
    int hold_left;
    int holds_served;
    bit rx_low;
    rx_mode = 0;
    mode_left = 0;
    rx_run = 0;
    hold_left = 0;
    holds_served = 0;
    rx_low = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(200, 3000);
      end else begin
        mode_left--;
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          default: begin
            if (rx_run == 0) begin
              rx_low = !rx_low;
              rx_run = rx_low ? $urandom_range(1, 90) : $urandom_range(1, 6);
            end else begin
              rx_run--;
            end
            out_ch.ready <= !rx_low;
          end
        endcase
      end
    end
  end

  task automatic pause_sender(input int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_packet(input ptm_in_t pkt);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data <= pkt;
    do @(posedge clk); while (!in_ch.ready);
    pending_reports.push_back(predict_report(pkt));
    gen_stamp = pkt.stamp;
    gen_pos = pkt.device_pos;
    gen_frames = pkt.frame_count;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, gap_max);
      // zero gap keeps valid high into the next beat
      if (gap > 0) pause_sender(gap);
    end
  endtask

  task automatic send_fields(input logic [15:0] frames, input logic [63:0] pos,
                             input logic [63:0] stamp, input logic disc, input logic serr);
    ptm_in_t p;
    p.frame_count = frames;
    p.device_pos = pos;
    p.stamp = stamp;
    p.discontinuity = disc;
    p.stamp_error = serr;
    send_packet(p);
  endtask

  task automatic wait_for_reports();
    pause_sender(1);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [PTM_ADDR_W-1:0] addr, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read(input logic [PTM_ADDR_W-1:0] addr, output logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    value = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] rate_word, input logic [31:0] tol_word);
    logic [31:0] readback;
    wait_for_reports();
    cfg_write(RATE_ADDR, rate_word);
    cfg_write(TOL_ADDR, tol_word);
    rate_reg = rate_word[PTM_RATE_W-1:0];
    tol_reg = tol_word;
    cfg_read(RATE_ADDR, readback);
    check_field("rate readback", 64'(rate_reg), 64'(readback));
    cfg_read(TOL_ADDR, readback);
    check_field("gap_tolerance readback", 64'(tol_reg), 64'(readback));
  endtask

  // mostly plausible packets continuing the stream, the rest flagged, late or noise
  task automatic send_stream_packet();
    ptm_in_t     p;
    int          kind;
    logic [63:0] jitter;
    kind = $urandom_range(0, 99);
    p.frame_count = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2400));
    p.device_pos = gen_pos + 64'(gen_frames);
    p.stamp = gen_stamp + step_ticks(gen_frames);
    p.discontinuity = 1'b0;
    p.stamp_error = 1'b0;
    if (kind < 70) begin
      case ($urandom_range(0, 3))
        0: jitter = 64'd0;
        1: jitter = 64'($urandom_range(0, 4000)) - 64'd2000;
        2: jitter = {32'd0, tol_reg} + 64'($urandom_range(0, 1));
        default: jitter = {32'd0, $urandom};
      endcase
      if ($urandom_range(0, 1) == 1) jitter = -jitter;
      p.stamp = p.stamp + jitter;
      if ($urandom_range(0, 19) == 0) p.device_pos = gen_pos - 64'($urandom_range(1, 5000));
    end else if (kind < 80) begin
      {p.discontinuity, p.stamp_error} = 2'($urandom_range(1, 3));
    end else if (kind < 90) begin
      p.stamp = gen_stamp - 64'($urandom_range(0, 100000));
    end else begin
      p.frame_count = 16'($urandom);
      p.device_pos = {$urandom, $urandom};
      p.stamp = {$urandom, $urandom};
      p.discontinuity = 1'($urandom_range(0, 1));
      p.stamp_error = 1'($urandom_range(0, 1));
    end
    send_packet(p);
  endtask

  task automatic test_step_checks();
    gap_max = 3;
    send_fields(16'd480, 64'd1000, 64'd5_000_000, 1'b0, 1'b0);
    send_fields(16'd480, 64'd1480, gen_stamp + step_ticks(16'd480), 1'b0, 1'b0);
    // error right at the tolerance, then one tick past it
    send_fields(16'd480, 64'd1960, gen_stamp + step_ticks(16'd480) + {32'd0, tol_reg},
                1'b0, 1'b0);
    send_fields(16'd480, 64'd2440,
                gen_stamp + step_ticks(16'd480) + {32'd0, tol_reg} + 64'd1, 1'b0, 1'b0);
    // stamp steps back and the position regresses
    send_fields(16'd480, 64'd100, 64'd4_000_000, 1'b0, 1'b0);
  endtask

  task automatic test_flagged_packets();
    send_fields(16'd480, gen_pos + 64'(gen_frames), gen_stamp + 64'd100000, 1'b1, 1'b0);
    send_fields(16'd480, gen_pos + 64'(gen_frames), gen_stamp + 64'd100000, 1'b0, 1'b1);
    send_fields(16'd480, gen_pos + 64'(gen_frames), gen_stamp + 64'd100000, 1'b1, 1'b1);
  endtask

  task automatic test_field_extremes();
    // new baseline after the broken timeline
    send_fields(16'hFFFF, 64'd0, 64'd0, 1'b0, 1'b0);
    send_fields(16'd0, '1, '1, 1'b0, 1'b0);
    send_fields(16'd0, 64'd7, 64'd100, 1'b0, 1'b0);
  endtask

  task automatic test_rate_and_tolerance_extremes();
    // zero rate counts as one frame per second
    set_config(32'd0, 32'd0);
    send_fields(16'hFFFF, 64'd10, 64'd1000, 1'b0, 1'b0);
    send_fields(16'hFFFF, 64'd65545, gen_stamp + step_ticks(16'hFFFF), 1'b0, 1'b0);
    send_fields(16'd1, 64'd131080, gen_stamp + step_ticks(16'hFFFF) + 64'd1, 1'b0, 1'b0);
    set_config(32'd384000, 32'hFFFF_FFFF);
    send_fields(16'd1, gen_pos + 64'd1, gen_stamp + step_ticks(16'd1) + 64'hFFFF_FFFF,
                1'b0, 1'b0);
    send_fields(16'd1, gen_pos + 64'd1, gen_stamp + step_ticks(16'd1) + 64'h1_0000_0000,
                1'b0, 1'b0);
    // bits above the rate field are dropped, leaving a rate of one
    set_config(32'hFFF8_0001, 32'd5);
    send_fields(16'd2, gen_pos + 64'd1, gen_stamp + step_ticks(16'd1) + 64'd5, 1'b0, 1'b0);
    send_fields(16'd2, gen_pos + 64'd2, gen_stamp + step_ticks(16'd2) - 64'd6, 1'b0, 1'b0);
    set_config(32'(PTM_RATE_RESET), PTM_TOL_RESET);
  endtask

  task automatic test_output_backpressure();
    wait_for_reports();
    gap_max = 0;
    hold_requests++;
    repeat (12) send_stream_packet();
    wait_for_reports();
  endtask

  task automatic run_stream_phase(input logic [31:0] rate_word, input logic [31:0] tol_word,
                                  input int count, input int gmax);
    set_config(rate_word, tol_word);
    gap_max = gmax;
    repeat (count) send_stream_packet();
  endtask

  task automatic test_random_streams();
    run_stream_phase(32'd48000, 32'd10000, 70, 0);
    run_stream_phase(32'd44100, 32'd500, 70, 40);
    run_stream_phase(32'd384000, 32'd0, 70, 8);
    run_stream_phase(32'd8000, 32'd100000, 70, 60);
    run_stream_phase(32'd1, 32'hFFFF_FFFF, 35, 0);
    run_stream_phase(32'h7FFFF, 32'd0, 35, 20);
    run_stream_phase(32'($urandom_range(1, 384000)), 32'($urandom_range(0, 200000)), 70, 30);
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    rst_n <= 1'b0;
    rate_reg = PTM_RATE_RESET;
    tol_reg = PTM_TOL_RESET;
    disc_cnt = '0;
    serr_cnt = '0;
    gap_cnt = '0;
    regr_cnt = '0;
    tl_valid = 1'b0;
    base_stamp = '0;
    last_stamp = '0;
    last_pos = '0;
    last_frames = '0;
    span_acc = '0;
    frames_acc = '0;
    gen_stamp = '0;
    gen_pos = '0;
    gen_frames = '0;
    gap_max = 0;
    burst_left = 1;
    hold_requests = 0;
    fault_count = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_step_checks();
    test_flagged_packets();
    test_field_extremes();
    test_rate_and_tolerance_extremes();
    test_output_backpressure();
    test_random_streams();

    wait_for_reports();
    repeat (60) @(posedge clk);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
